>>> hdl/vhl_pkg.sv
// ----------------------------------------------------------------------------
// vhl_pkg
// Shared widths, angle constants and the CORDIC arctangent table for the
// vector heading and length unit.
// ----------------------------------------------------------------------------
package vhl_pkg;

    localparam int ANG_W        = 32;   // binary angle, 2^32 per turn
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_IDX_W   = 5;
    localparam int NORM_W       = 42;   // normalized components, signed
    localparam int CORD_W       = 45;   // CORDIC datapath, signed, covers gain
    localparam int HEAD_W       = 16;
    localparam int LEN_W        = 16;
    localparam int PROD_W       = ANG_W + HEAD_W;

    localparam logic [HEAD_W-1:0] TURN_OUT  = 16'd46080;   // 360 * 128
    localparam logic [HEAD_W-1:0] HEAD_ZERO = 16'd11520;   // 90 * 128
    localparam logic [LEN_W-1:0]  LEN_MAX   = 16'hFFFF;

    localparam logic [ANG_W-1:0]  QUARTER_BIN = 32'h4000_0000;
    localparam logic [ANG_W-1:0]  HALF_BIN    = 32'h8000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF  = 48'h0000_8000_0000;

    typedef struct packed {
        logic en;    // pipeline advance
        logic vld;   // item present at this stage
    } t_pipe_ctl;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0029;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0003;
            5'd29:   val = 32'h0000_0001;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> hdl/vector_heading_and_length_unit.sv
// ----------------------------------------------------------------------------
// vector_heading_and_length_unit
// Compass heading (degrees * 128) and rounded Euclidean length of a 2-D
// vector, fully pipelined.
// ----------------------------------------------------------------------------
//  Port group   Dir  tdata fields (low bit first)
//  s_axis       in   x_coord[W-1:0], y_coord[W-1:0], zero pad to bytes
//  m_axis       out  heading[15:0], length[15:0]
//
//  One transfer in and one out per clock, sustained while the output is not stalled.
//  Latency from input transfer to o_m_axis_tvalid is set by the 30-stage
//  CORDIC chain and its normalizer.
//  i_rst_n is synchronous; it clears all valid bits and the skid stage.
//  A stalled output fills one skid register, then o_s_axis_tready drops
//  and the whole pipeline holds.
// ----------------------------------------------------------------------------
module vector_heading_and_length_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // x_coord, y_coord, zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // heading, length
    output logic [vhl_pkg::HEAD_W+vhl_pkg::LEN_W-1:0] o_m_axis_tdata
);
    import vhl_pkg::*;

    localparam int OUT_W = HEAD_W + LEN_W;
    localparam int LAT_A = $clog2(COORD_WIDTH) + 33;
    localparam int LAT_S = COORD_WIDTH + 3;
    localparam int PAD   = LAT_A - LAT_S;

    logic                          pipe_en;
    t_pipe_ctl                     ctl;
    logic                          r_in_vld;
    logic signed [COORD_WIDTH-1:0] r_x, r_y;
    logic                          head_vld;
    logic [HEAD_W-1:0]             heading;
    logic [LEN_W-1:0]              length;
    logic [LEN_W-1:0]              r_len_dly [0:PAD-1];
    logic [OUT_W-1:0]              pipe_data;
    logic                          r_out_vld, r_skid_vld;
    logic [OUT_W-1:0]              r_out_data, r_skid_data;

    assign pipe_en         = !r_skid_vld;
    assign o_s_axis_tready = pipe_en;
    assign ctl.en          = pipe_en;
    assign ctl.vld         = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (pipe_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_x <= $signed(i_s_axis_tdata[COORD_WIDTH-1:0]);
            r_y <= $signed(i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
        end
    end

    vhl_atan #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_atan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_x       (r_x),
        .i_y       (r_y),
        .o_vld     (head_vld),
        .o_heading (heading)
    );

    vhl_isqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_isqrt (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_x      (r_x),
        .i_y      (r_y),
        .o_length (length)
    );

    // length path is shorter; align it with the heading
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_len_dly[0] <= length;
            for (int p = 1; p < PAD; p++) begin
                r_len_dly[p] <= r_len_dly[p-1];
            end
        end
    end

    assign pipe_data = {r_len_dly[PAD-1], heading};

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pipe_en) begin
            if (head_vld) begin
                if (!r_out_vld || i_m_axis_tready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end else if (i_m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (head_vld) begin
                if (!r_out_vld || i_m_axis_tready) begin
                    r_out_data <= pipe_data;
                end else begin
                    r_skid_data <= pipe_data;
                end
            end
        end else if (i_m_axis_tready) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without a valid output");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_m_axis_tready |=> r_skid_vld && $stable(r_skid_data))
        else $error("skid entry lost while output stalled");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[HEAD_W-1:0] < TURN_OUT))
        else $error("heading outside one turn");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(head_vld) && $past(r_out_vld)
                              && !$past(i_m_axis_tready))
        else $error("skid filled without a stalled result");
`endif

endmodule

>>> hdl/vhl_atan.sv
// ----------------------------------------------------------------------------
// vhl_atan
// Pipelined heading path: half-plane fold, staged normalizer, 30 CORDIC
// vectoring stages and scaling of the binary angle to degrees * 128.
// ----------------------------------------------------------------------------
module vhl_atan #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vhl_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [COORD_WIDTH-1:0]     i_x,
    input  logic signed [COORD_WIDTH-1:0]     i_y,
    output logic                              o_vld,
    output logic        [vhl_pkg::HEAD_W-1:0] o_heading
);
    import vhl_pkg::*;

    localparam int NORM_STEPS = $clog2(COORD_WIDTH);
    localparam int MAG_W      = NORM_W - 1;
    localparam int PRE_SHIFT  = MAG_W - COORD_WIDTH;

    // ---------------- fold into right half plane ----------------
    logic signed [NORM_W-1:0] x_ext, y_ext, cx, cy, abs_cy;
    logic        [MAG_W-1:0]  mag;
    logic                     x_neg, is_zero;

    assign x_ext   = {{(NORM_W-COORD_WIDTH){i_x[COORD_WIDTH-1]}}, i_x};
    assign y_ext   = {{(NORM_W-COORD_WIDTH){i_y[COORD_WIDTH-1]}}, i_y};
    assign x_neg   = i_x[COORD_WIDTH-1];
    assign cx      = x_neg ? -x_ext : x_ext;
    assign cy      = x_neg ? -y_ext : y_ext;
    assign abs_cy  = cy[NORM_W-1] ? -cy : cy;
    assign mag     = (cx[MAG_W-1:0] > abs_cy[MAG_W-1:0]) ? cx[MAG_W-1:0] : abs_cy[MAG_W-1:0];
    assign is_zero = (i_x == '0) && (i_y == '0);

    // ---------------- normalizer, one shift step per stage ----------------
    logic                     r_n_vld  [0:NORM_STEPS];
    logic                     r_n_zero [0:NORM_STEPS];
    logic                     r_n_neg  [0:NORM_STEPS];
    logic signed [NORM_W-1:0] r_n_cx   [0:NORM_STEPS];
    logic signed [NORM_W-1:0] r_n_cy   [0:NORM_STEPS];
    logic        [MAG_W-1:0]  r_n_mag  [0:NORM_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_n_vld[0] <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_n_zero[0] <= is_zero;
            r_n_neg[0]  <= x_neg;
            r_n_cx[0]   <= cx <<< PRE_SHIFT;
            r_n_cy[0]   <= cy <<< PRE_SHIFT;
            r_n_mag[0]  <= mag << PRE_SHIFT;
        end
    end

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic lead_zero;

        assign lead_zero = (r_n_mag[k][MAG_W-1 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_vld[k+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_n_vld[k+1] <= r_n_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_n_zero[k+1] <= r_n_zero[k];
                r_n_neg[k+1]  <= r_n_neg[k];
                r_n_cx[k+1]   <= lead_zero ? (r_n_cx[k] <<< SH) : r_n_cx[k];
                r_n_cy[k+1]   <= lead_zero ? (r_n_cy[k] <<< SH) : r_n_cy[k];
                r_n_mag[k+1]  <= lead_zero ? (r_n_mag[k] << SH) : r_n_mag[k];
            end
        end
    end

    // ---------------- CORDIC vectoring stages ----------------
    logic signed [CORD_W-1:0] c0_x, c0_y;
    logic        [ANG_W-1:0]  c0_z;

    assign c0_x = {{(CORD_W-NORM_W){r_n_cx[NORM_STEPS][NORM_W-1]}}, r_n_cx[NORM_STEPS]};
    assign c0_y = {{(CORD_W-NORM_W){r_n_cy[NORM_STEPS][NORM_W-1]}}, r_n_cy[NORM_STEPS]};
    assign c0_z = r_n_neg[NORM_STEPS] ? HALF_BIN : '0;

    logic                     r_c_vld  [0:CORDIC_STEPS-1];
    logic                     r_c_zero [0:CORDIC_STEPS-1];
    logic signed [CORD_W-1:0] r_c_x    [0:CORDIC_STEPS-1];
    logic signed [CORD_W-1:0] r_c_y    [0:CORDIC_STEPS-1];
    logic        [ANG_W-1:0]  r_c_z    [0:CORDIC_STEPS-1];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CORD_W-1:0] cur_x, cur_y, dx, dy, n_x, n_y;
        logic        [ANG_W-1:0]  cur_z, step_ang, n_z;
        logic                     cur_vld, cur_zero, y_neg;

        if (i == 0) begin : g_first
            assign cur_x    = c0_x;
            assign cur_y    = c0_y;
            assign cur_z    = c0_z;
            assign cur_vld  = r_n_vld[NORM_STEPS];
            assign cur_zero = r_n_zero[NORM_STEPS];
        end else begin : g_next
            assign cur_x    = r_c_x[i-1];
            assign cur_y    = r_c_y[i-1];
            assign cur_z    = r_c_z[i-1];
            assign cur_vld  = r_c_vld[i-1];
            assign cur_zero = r_c_zero[i-1];
        end

        assign dx       = cur_y >>> i;
        assign dy       = cur_x >>> i;
        assign y_neg    = cur_y[CORD_W-1];
        assign step_ang = atan_lut(STEP_IDX_W'(i));
        assign n_x      = y_neg ? (cur_x - dx) : (cur_x + dx);
        assign n_y      = y_neg ? (cur_y + dy) : (cur_y - dy);
        assign n_z      = y_neg ? (cur_z - step_ang) : (cur_z + step_ang);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i] <= 1'b0;
            end else if (i_ctl.en) begin
                r_c_vld[i] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_c_zero[i] <= cur_zero;
                r_c_x[i]    <= n_x;
                r_c_y[i]    <= n_y;
                r_c_z[i]    <= n_z;
            end
        end
    end

    // ---------------- scale to degrees * 128 ----------------
    logic [ANG_W-1:0]  bin_head;
    logic [PROD_W-1:0] n_prod, rounded;
    logic [HEAD_W-1:0] scaled, n_head;
    logic              r_m_vld, r_m_zero, r_h_vld;
    logic [PROD_W-1:0] r_prod;
    logic [HEAD_W-1:0] r_head;

    assign bin_head = r_c_z[CORDIC_STEPS-1] + QUARTER_BIN;   // compass offset
    assign n_prod   = PROD_W'(bin_head) * PROD_W'(TURN_OUT);
    assign rounded  = r_prod + ROUND_HALF;
    assign scaled   = rounded[PROD_W-1:ANG_W];
    assign n_head   = r_m_zero ? HEAD_ZERO : ((scaled >= TURN_OUT) ? '0 : scaled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_m_vld <= r_c_vld[CORDIC_STEPS-1];
            r_h_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_m_zero <= r_c_zero[CORDIC_STEPS-1];
            r_prod   <= n_prod;
            r_head   <= n_head;
        end
    end

    assign o_vld     = r_h_vld;
    assign o_heading = r_head;

endmodule

>>> hdl/vhl_isqrt.sv
// ----------------------------------------------------------------------------
// vhl_isqrt
// Pipelined length path: squares, sum, one root bit per stage, then round
// half up and clamp to the output width.
// ----------------------------------------------------------------------------
module vhl_isqrt #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [COORD_WIDTH-1:0]    i_x,
    input  logic signed [COORD_WIDTH-1:0]    i_y,
    output logic        [vhl_pkg::LEN_W-1:0] o_length
);
    import vhl_pkg::*;

    localparam int RW = 2 * COORD_WIDTH;

    logic [COORD_WIDTH-1:0] ax, ay;
    logic [RW-1:0]          r_sq_x, r_sq_y;
    logic [RW-1:0]          r_rem  [0:COORD_WIDTH];
    logic [RW-1:0]          r_root [0:COORD_WIDTH];

    assign ax = i_x[COORD_WIDTH-1] ? (~$unsigned(i_x) + COORD_WIDTH'(1)) : $unsigned(i_x);
    assign ay = i_y[COORD_WIDTH-1] ? (~$unsigned(i_y) + COORD_WIDTH'(1)) : $unsigned(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x    <= RW'(ax) * RW'(ax);
            r_sq_y    <= RW'(ay) * RW'(ay);
            r_rem[0]  <= r_sq_x + r_sq_y;
            r_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_digit
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (COORD_WIDTH - 1 - j));
        logic [RW:0]   trial;
        logic          fits;
        logic [RW-1:0] n_rem, n_root;

        assign trial  = {1'b0, r_root[j]} + {1'b0, BIT};
        assign fits   = ({1'b0, r_rem[j]} >= trial);
        assign n_rem  = fits ? (r_rem[j] - trial[RW-1:0]) : r_rem[j];
        assign n_root = fits ? ((r_root[j] >> 1) + BIT) : (r_root[j] >> 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= n_rem;
                r_root[j+1] <= n_root;
            end
        end
    end

    logic [RW-1:0]    root_rnd;
    logic [LEN_W-1:0] n_len, r_len;

    // remainder above root means the fraction is at least one half
    assign root_rnd = r_root[COORD_WIDTH]
                    + RW'(r_rem[COORD_WIDTH] > r_root[COORD_WIDTH]);
    assign n_len    = (root_rnd > RW'(LEN_MAX)) ? LEN_MAX : root_rnd[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= n_len;
        end
    end

    assign o_length = r_len;

endmodule

>>> dv/tb_vector_heading_and_length_unit.sv
// ----------------------------------------------------------------------------
// tb_vector_heading_and_length_unit
// Self-checking bench for the vector heading and length unit. A table of
// corner vectors is sent first, and then about 1150 random vectors of
// several shapes. Every output transfer is compared, heading and length
// separately, with typed-in values or a bit-exact CORDIC and isqrt predictor.
// Both stream sides idle at random. The receiver also holds off for one long
// stretch so that the pipeline fills up and back-pressures its input.
// ----------------------------------------------------------------------------
module tb_vector_heading_and_length_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W  = 16;
    localparam int TDATA_W  = ((2*COORD_W+7)/8)*8;
    localparam int HEAD_W   = vhl_pkg::HEAD_W;
    localparam int LEN_W    = vhl_pkg::LEN_W;

    localparam int N_RAND_IDLE_A  = 500;
    localparam int N_RAND_QUIET   = 300;
    localparam int N_RAND_IDLE_B  = 350;
    localparam int IDLE_PCT       = 28;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 60;     // longer than the pipeline latency
    localparam int STALL_LIMIT    = 5000;

    localparam int          ANGLE_STEPS = 30;
    localparam logic [15:0] DEG_FULL    = 16'd46080;    // 360 * 128
    localparam logic [15:0] DEG_90      = 16'd11520;

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURN [ANGLE_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
    };

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [HEAD_W-1:0]  heading;
        logic [LEN_W-1:0]   length;
    } t_polar_due;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               known;      // expected values typed in below
        logic [HEAD_W-1:0]  heading;
        logic [LEN_W-1:0]   length;
    } t_probe_row;

    localparam int N_PROBES = 23;
    localparam t_probe_row PROBES [N_PROBES] = '{
        '{16'h0000, 16'h0000, 1'b1, 16'd11520, 16'd0},      // zero vector
        '{16'h7FFF, 16'h0000, 1'b1, 16'd11520, 16'd32767},
        '{16'h0000, 16'h7FFF, 1'b1, 16'd23040, 16'd32767},
        '{16'h8000, 16'h0000, 1'b1, 16'd34560, 16'd32768},
        '{16'h0000, 16'h8000, 1'b1, 16'd0,     16'd32768},  // wraps to 0
        '{16'h8000, 16'h8000, 1'b1, 16'd40320, 16'd46341},  // longest vector
        '{16'h7FFF, 16'h7FFF, 1'b1, 16'd17280, 16'd46340},
        '{16'h7FFF, 16'h8000, 1'b0, 16'd0,     16'd0},
        '{16'h8000, 16'h7FFF, 1'b0, 16'd0,     16'd0},
        '{16'h0001, 16'h0000, 1'b1, 16'd11520, 16'd1},
        '{16'hFFFF, 16'h0000, 1'b1, 16'd34560, 16'd1},
        '{16'h0000, 16'h0001, 1'b1, 16'd23040, 16'd1},
        '{16'h0000, 16'hFFFF, 1'b1, 16'd0,     16'd1},
        '{16'h0001, 16'h0001, 1'b1, 16'd17280, 16'd1},
        '{16'hFFFF, 16'hFFFF, 1'b1, 16'd40320, 16'd1},
        '{16'h0003, 16'h0004, 1'b0, 16'd0,     16'd0},
        '{16'hFFFD, 16'hFFFC, 1'b0, 16'd0,     16'd0},
        '{16'h0001, 16'h8000, 1'b0, 16'd0,     16'd0},
        '{16'hFFFF, 16'h8000, 1'b0, 16'd0,     16'd0},
        '{16'h8000, 16'h0001, 1'b0, 16'd0,     16'd0},
        '{16'h8000, 16'hFFFF, 1'b0, 16'd0,     16'd0},
        '{16'h7FFF, 16'h0001, 1'b0, 16'd0,     16'd0},
        '{16'h7FFF, 16'hFFFF, 1'b0, 16'd0,     16'd0}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_tvalid;
    logic                     o_s_axis_tready;
    logic [TDATA_W-1:0]       s_tdata;          // x_coord, y_coord
    logic                     o_m_axis_tvalid;
    logic                     m_tready;
    logic [HEAD_W+LEN_W-1:0]  o_m_axis_tdata;   // heading, length

    logic       quiet;          // no idling on either side
    logic       hold_req;       // ask the receiver for one long hold-off
    int         err_count = 0;
    int         stall_cycles = 0;
    t_polar_due polar_due_q [$];

    wire s_xfer = s_tvalid && o_s_axis_tready;
    wire m_xfer = o_m_axis_tvalid && m_tready;

    vector_heading_and_length_unit #(
        .COORD_WIDTH     (COORD_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Compass heading, degrees * 128, via 30-step vectoring CORDIC
    function automatic logic [HEAD_W-1:0] cordic_heading(input longint x, input longint y);
        longint      cx, cy, dx, dy, mag;
        logic [31:0] z;
        logic [31:0] h;
        logic [63:0] prod;
        if (x == 0 && y == 0) begin
            return DEG_90;
        end
        cx = x;
        cy = y;
        z  = 32'h0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z  = 32'h8000_0000;
        end
        mag = (cx > ((cy < 0) ? -cy : cy)) ? cx : ((cy < 0) ? -cy : cy);
        while (mag < (longint'(1) << 40)) begin
            mag = mag * 2;
            cx  = cx * 2;
            cy  = cy * 2;
        end
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_TURN[i];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_TURN[i];
            end
        end
        h    = z + 32'h4000_0000;
        prod = ({32'h0, h} * 64'(DEG_FULL) + 64'h8000_0000) >> 32;
        if (prod >= 64'(DEG_FULL)) begin
            prod = 64'h0;
        end
        return prod[HEAD_W-1:0];
    endfunction

    // Rounded sqrt(x^2 + y^2), saturating at the field width
    function automatic logic [LEN_W-1:0] rounded_length(input longint x, input longint y);
        logic [63:0] rem, root, probe;
        rem   = 64'(x * x + y * y);
        root  = 64'h0;
        probe = 64'h1 << 62;
        while (probe > rem) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rem > root) begin
            root = root + 1;
        end
        if (root > 64'hFFFF) begin
            root = 64'hFFFF;
        end
        return root[LEN_W-1:0];
    endfunction

    function automatic t_polar_due predict_polar(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
        t_polar_due r;
        longint     sx, sy;
        sx        = longint'($signed(x));
        sy        = longint'($signed(y));
        r.x       = x;
        r.y       = y;
        r.heading = cordic_heading(sx, sy);
        r.length  = rounded_length(sx, sy);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Offer one vector; returns at the edge where the transfer happens
    task automatic push_vector(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic known, input logic [HEAD_W-1:0] exp_heading,
                               input logic [LEN_W-1:0] exp_length);
        t_polar_due due;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({y, x});
        do @(posedge i_clk); while (!o_s_axis_tready);
        due = predict_polar(x, y);
        if (known) begin
            due.heading = exp_heading;
            due.length  = exp_length;
        end
        polar_due_q.push_back(due);
    endtask

    function automatic logic [COORD_W-1:0] random_coord(input int shape);
        logic [COORD_W-1:0] v;
        case (shape)
            0:       v = COORD_W'($urandom_range(16)) - COORD_W'(8);
            1:       v = COORD_W'($urandom_range(2048)) - COORD_W'(1024);
            2:       v = 16'h8000 + COORD_W'($urandom_range(7));
            3:       v = 16'h7FFF - COORD_W'($urandom_range(7));
            default: v = COORD_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic push_random(input int count);
        logic [COORD_W-1:0] x, y;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: begin            // small magnitudes
                    x = random_coord(0);
                    y = random_coord(0);
                end
                1: begin            // medium magnitudes
                    x = random_coord(1);
                    y = random_coord(1);
                end
                2: begin            // on an axis
                    x = random_coord($urandom_range(4));
                    y = '0;
                    if ($urandom_range(1) != 0) begin
                        y = x;
                        x = '0;
                    end
                end
                3: begin            // diagonals
                    x = random_coord(4);
                    y = ($urandom_range(1) != 0) ? x : -x;
                end
                4: begin            // near full scale
                    x = random_coord($urandom_range(2, 3));
                    y = random_coord($urandom_range(2, 4));
                end
                default: begin
                    x = random_coord(4);
                    y = random_coord(4);
                end
            endcase
            push_vector(x, y, 1'b0, '0, '0);
        end
    endtask

    // Receiver: random idling, plus one long hold-off on request
    initial begin : sink_proc
        int unsigned hold_left;
        bit          hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_polar_due due;
        if (i_rst_n && m_xfer) begin
            if (polar_due_q.size() == 0) begin
                flag_mismatch($sformatf("result %h with no vector pending", o_m_axis_tdata));
            end else begin
                due = polar_due_q.pop_front();
                if (o_m_axis_tdata[HEAD_W-1:0] != due.heading) begin
                    flag_mismatch($sformatf("x=%0d y=%0d heading %0d, want %0d",
                        $signed(due.x), $signed(due.y),
                        o_m_axis_tdata[HEAD_W-1:0], due.heading));
                end
                if (o_m_axis_tdata[HEAD_W +: LEN_W] != due.length) begin
                    flag_mismatch($sformatf("x=%0d y=%0d length %0d, want %0d",
                        $signed(due.x), $signed(due.y),
                        o_m_axis_tdata[HEAD_W +: LEN_W], due.length));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || s_xfer || m_xfer) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stim_proc
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        quiet    <= 1'b0;
        hold_req <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);

        for (int r = 0; r < N_PROBES; r++) begin
            push_vector(PROBES[r].x, PROBES[r].y, PROBES[r].known,
                        PROBES[r].heading, PROBES[r].length);
        end

        push_random(N_RAND_IDLE_A);

        // back-to-back stretch; receiver stalls long enough to fill the pipe
        quiet    <= 1'b1;
        hold_req <= 1'b1;
        push_random(N_RAND_QUIET);
        quiet    <= 1'b0;

        push_random(N_RAND_IDLE_B);
        s_tvalid <= 1'b0;

        while (polar_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
